// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk_i, off while rst_ni is low.
`define HCBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define HCBP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/hcbp_pkg.sv =====
package hcbp_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned OP_W         = 2;
  localparam int unsigned SYM_FIELD_W  = 8;
  localparam int unsigned CODE_FIELD_W = 32;
  localparam int unsigned LEN_FIELD_W  = 6;
  localparam int unsigned BYTE_W       = 8;

  // Packer state: up to seven pending bits
  localparam int unsigned ACC_W  = 7;
  localparam int unsigned PEND_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  // Command from the control FSM to the packer
  typedef struct packed {
    logic                    start;
    logic                    flush;
    logic [CODE_FIELD_W-1:0] code;
    logic [LEN_FIELD_W-1:0]  len;
  } pk_cmd_t;

endpackage

// ===== rtl/hcbp_if.sv =====
// Request channel: one load, encode or flush request per handshake
interface hcbp_req_if import hcbp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [SYM_FIELD_W-1:0]  symbol;
  logic [CODE_FIELD_W-1:0] code_bits;
  logic [LEN_FIELD_W-1:0]  code_length;

  modport source (output valid, operation, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, operation, symbol, code_bits, code_length, output ready);
endinterface

// Result channel: one packed byte per handshake
interface hcbp_res_if import hcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_in_run;

  modport source (output valid, out_byte, last_in_run, input ready);
  modport sink   (input valid, out_byte, last_in_run, output ready);
endinterface

// ===== rtl/huffman_code_table_bit_packer.sv =====
// Huffman code table and bit packer.
// Request channel req_i: a load request writes one table entry (code and
// length), an encode request appends the code of its symbol, MSB first, to
// the bit accumulator, a flush request pads the pending bits with zeros and
// sends them as one byte. Result channel res_o: packed bytes, earliest bit
// in bit 7; last_in_run marks the final byte caused by a request.
// One request is in progress at a time. A load writes its entry when it
// is taken. An encode steps through the table read, forming the bit word,
// one step per byte (up to four bytes) and retiring; its first byte passes
// the table read, bit word and output registers. A flush forms its padded
// byte, sends it only when bits are pending, and retires. The code table
// is a single-port-write, registered-read memory; the packer sends one
// byte per cycle while res_o is not stalled. When res_o stalls, the packer
// holds in its output register and req_i.ready stays low until the
// request has retired; a request retires only after its final byte has
// left the output register.
// Reset clears the accumulator, the pending count and the handshakes; the
// table is not cleared and an entry must be loaded before it is encoded.
module huffman_code_table_bit_packer import hcbp_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input logic        clk_i,
  input logic        rst_ni,
  hcbp_req_if.sink   req_i,
  hcbp_res_if.source res_o
);

  localparam int unsigned LEN_CAP = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam int unsigned LEN_W   = $clog2(LEN_CAP + 1);
  localparam int unsigned SYM_W   = $clog2(SYMBOL_COUNT);
  localparam int unsigned MEM_W   = LEN_CAP + LEN_W;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e            state_q, state_d;
  logic              accept;
  logic              sym_ok;
  logic              mem_we;
  logic              mem_re;
  logic [LEN_W-1:0]  len_sat;
  logic [LEN_CAP-1:0] code_m;
  logic [MEM_W-1:0]  mem_rdata;
  pk_cmd_t           pk_cmd;
  logic              pk_busy;

  assign req_i.ready = (state_q == ST_IDLE) && !pk_busy;
  assign accept      = req_i.valid && req_i.ready;
  assign sym_ok      = ({1'b0, req_i.symbol} < 9'(SYMBOL_COUNT));

  // saturate the length and drop code bits above it
  assign len_sat = (req_i.code_length > LEN_FIELD_W'(LEN_CAP)) ?
                   LEN_W'(LEN_CAP) : LEN_W'(req_i.code_length);

  always_comb begin
    for (int i = 0; i < LEN_CAP; i++) begin
      code_m[i] = req_i.code_bits[i] && (LEN_W'(i) < len_sat);
    end
  end

  // request decode and command to the packer
  always_comb begin
    state_d = state_q;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    pk_cmd  = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(req_i.operation))
            OP_LOAD: begin
              mem_we = sym_ok;
            end
            OP_ENCODE: begin
              if (sym_ok) begin
                mem_re  = 1'b1;
                state_d = ST_LOOKUP;
              end
            end
            OP_FLUSH: begin
              pk_cmd.start = 1'b1;
              pk_cmd.flush = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        pk_cmd.start = 1'b1;
        pk_cmd.code  = CODE_FIELD_W'(mem_rdata[LEN_CAP-1:0]);
        pk_cmd.len   = LEN_FIELD_W'(mem_rdata[MEM_W-1:LEN_CAP]);
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  hcbp_code_mem #(
    .DEPTH  (SYMBOL_COUNT),
    .ADDR_W (SYM_W),
    .DATA_W (MEM_W)
  ) u_code_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (req_i.symbol[SYM_W-1:0]),
    .wdata_i ({len_sat, code_m}),
    .re_i    (mem_re),
    .raddr_i (req_i.symbol[SYM_W-1:0]),
    .rdata_o (mem_rdata)
  );

  hcbp_packer #(
    .LEN_CAP (LEN_CAP)
  ) u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pk_cmd),
    .busy_o      (pk_busy),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_byte_o  (res_o.out_byte),
    .out_last_o  (res_o.last_in_run)
  );

endmodule

// ===== rtl/hcbp_code_mem.sv =====
module hcbp_code_mem #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 38
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hcbp_packer.sv =====
module hcbp_packer import hcbp_pkg::*; #(
  parameter int unsigned LEN_CAP = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pk_cmd_t           cmd_i,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_last_o
);

  localparam int unsigned TOT_W = LEN_CAP + ACC_W;
  localparam int unsigned NB_W  = $clog2(TOT_W + 1);
  localparam int unsigned LEN_W = $clog2(LEN_CAP + 1);

  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic              busy_q, busy_d;
  logic [TOT_W-1:0]  tot_q, tot_d;
  logic [NB_W-1:0]   nb_q, nb_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;

  logic [LEN_W-1:0]  len;
  logic [BYTE_W-1:0] flush_byte;
  logic [NB_W-1:0]   shift;
  logic              advance;

  assign len        = cmd_i.len[LEN_W-1:0];
  assign flush_byte = BYTE_W'({1'b0, acc_q} << (4'd8 - {1'b0, pend_q}));
  assign shift      = nb_q - NB_W'(BYTE_W);
  assign advance    = !out_valid_q || out_ready_i;

  always_comb begin
    acc_d       = acc_q;
    pend_d      = pend_q;
    busy_d      = busy_q;
    tot_d       = tot_q;
    nb_d        = nb_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    // output register drains on a handshake
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.start) begin
      // form the bit word for this request
      busy_d = 1'b1;
      if (cmd_i.flush) begin
        if (pend_q != '0) begin
          tot_d = TOT_W'(flush_byte);
          nb_d  = NB_W'(BYTE_W);
        end else begin
          tot_d = '0;
          nb_d  = '0;
        end
      end else begin
        tot_d = (TOT_W'(acc_q) << len) | TOT_W'(cmd_i.code[LEN_CAP-1:0]);
        nb_d  = NB_W'(pend_q) + NB_W'(len);
      end
    end else if (busy_q && advance) begin
      if (nb_q >= NB_W'(BYTE_W)) begin
        // next byte from the top of the pending bits
        out_valid_d = 1'b1;
        out_byte_d  = BYTE_W'(tot_q >> shift);
        out_last_d  = (shift < NB_W'(BYTE_W));
        nb_d        = shift;
      end else begin
        // retire: keep the leftover bits
        acc_d  = tot_q[ACC_W-1:0] & ACC_W'((8'd1 << nb_q[PEND_W-1:0]) - 8'd1);
        pend_d = nb_q[PEND_W-1:0];
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pend_q      <= '0;
      busy_q      <= 1'b0;
      nb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      pend_q      <= pend_d;
      busy_q      <= busy_d;
      nb_q        <= nb_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    tot_q      <= tot_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign busy_o      = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/hcbp_checker.sv =====
`include "assert_macros.svh"

module hcbp_checker import hcbp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic [OP_W-1:0]   req_operation_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [BYTE_W-1:0] res_out_byte_i,
  input logic              res_last_i
);

  // a stalled byte stays put
  `HCBP_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i,
    res_valid_i && $stable(res_out_byte_i) && $stable(res_last_i), "stalled result changed")

  // no new request while a run is still mid-way
  `HCBP_ASSERT(a_no_req_mid_run, (req_valid_i && req_ready_i) |-> !(res_valid_i && !res_last_i),
    "request taken in the middle of a run")

  // bytes inside a run follow without a gap
  `HCBP_ASSERT_NEXT(a_run_back_to_back, res_valid_i && res_ready_i && !res_last_i,
    res_valid_i, "gap inside a run")

  // a load leaves the request channel ready in the next cycle
  `HCBP_ASSERT_NEXT(a_load_one_cycle,
    req_valid_i && req_ready_i && (req_operation_i == OP_LOAD), req_ready_i,
    "load did not retire in one cycle")

endmodule

bind huffman_code_table_bit_packer hcbp_checker u_hcbp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .req_operation_i (req_i.operation),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .res_out_byte_i  (res_o.out_byte),
  .res_last_i      (res_o.last_in_run)
);
